### rtl/array_list_engine_assert.svh
// assertion macros used by the list engine sequencer (alen_ctrl)
// each expects clk and arst_n in scope
`ifndef ARRAY_LIST_ENGINE_ASSERT_SVH
`define ARRAY_LIST_ENGINE_ASSERT_SVH

// condition holds at every edge outside reset
`define ALEN_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ALEN_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define ALEN_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/alen_pkg.sv
package alen_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int DATA_W    = 32;
	localparam int POS_W     = 6;
	localparam int CNT_W     = 7;
	localparam int CNT_MAX   = 127;
	localparam logic [CNT_W-1:0] CAP_RESET = 7'd6;

	// operation selector
	typedef enum logic [2:0] {
		K_APPEND = 3'd0,
		K_INSERT = 3'd1,
		K_DELETE = 3'd2,
		K_READ   = 3'd3,
		K_EDIT   = 3'd4,
		K_SEARCH = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BADPOS   = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SHIFT_UP,
		S_INS_PUT,
		S_SHIFT_DN,
		S_SEARCH,
		S_FINISH
	} state_t;

	typedef struct packed {
		kind_t                    kind;
		logic signed [DATA_W-1:0] data_value;
		logic [POS_W-1:0]         position;
	} item_t;

	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] read_value;
		logic [CNT_W-1:0]         element_count;
		logic                     found;
	} result_t;

endpackage

### rtl/alen_ram.sv
// single write port, single registered read port
module alen_ram #(
	parameter int DEPTH = alen_pkg::DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [AW-1:0]                    waddr,
	input  logic signed [alen_pkg::DATA_W-1:0] wdata,
	input  logic                             re,
	input  logic [AW-1:0]                    raddr,
	output logic signed [alen_pkg::DATA_W-1:0] rdata
);

	logic signed [alen_pkg::DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/alen_ctrl.sv
`include "array_list_engine_assert.svh"

// sequencer: walks the store one entry per cycle through a single +/-1 pointer unit
module alen_ctrl #(
	parameter int DEPTH = alen_pkg::DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  alen_pkg::item_t                    in_item,
	input  logic [alen_pkg::CNT_W-1:0]         cap_cfg,
	output logic                               out_valid,
	input  logic                               out_ready,
	output alen_pkg::result_t                  out_res,
	output logic                               ram_we,
	output logic [AW-1:0]                      ram_waddr,
	output logic signed [alen_pkg::DATA_W-1:0] ram_wdata,
	output logic                               ram_re,
	output logic [AW-1:0]                      ram_raddr,
	input  logic signed [alen_pkg::DATA_W-1:0] ram_rdata
);

	localparam int CW      = alen_pkg::CNT_W;
	localparam int CAP_MAX = (DEPTH < alen_pkg::CNT_MAX) ? DEPTH : alen_pkg::CNT_MAX;

	function automatic logic [AW-1:0] to_addr(input logic [CW-1:0] x);
		logic [CW+AW-1:0] w;
		w = {{AW{1'b0}}, x};
		return w[AW-1:0];
	endfunction

	alen_pkg::state_t state_q, state_d;

	logic [AW-1:0]                      clr_q;
	logic [CW-1:0]                      fill_q, fill_d;
	logic [CW-1:0]                      rd_q, rd_d;
	logic [CW-1:0]                      wr_q, wr_d;
	logic [alen_pkg::POS_W-1:0]         pos_q;
	logic signed [alen_pkg::DATA_W-1:0] data_q;
	alen_pkg::status_t                  status_q, status_d;
	logic                               found_q, found_d;
	logic                               rsel_q, rsel_d;
	logic                               out_valid_q;
	alen_pkg::result_t                  out_res_q;

	logic [CW-1:0] cap;
	logic [CW-1:0] in_pos;
	logic [CW-1:0] pos_w;
	logic          accept;
	logic [CW-1:0] base;
	logic          step_dn;
	logic [CW-1:0] nxt;
	logic          hit;
	logic          load_out;
	logic [CW-1:0] waddr_c;
	logic [CW-1:0] raddr_c;

	// shared pointer unit
	always_comb begin
		cap     = (cap_cfg > CW'(CAP_MAX)) ? CW'(CAP_MAX) : cap_cfg;
		in_pos  = {1'b0, in_item.position};
		pos_w   = {1'b0, pos_q};
		accept  = in_valid && in_ready;
		if (state_q == alen_pkg::S_IDLE) begin
			base    = (in_item.kind == alen_pkg::K_INSERT) ? fill_q : in_pos;
			step_dn = (in_item.kind == alen_pkg::K_INSERT);
		end else begin
			base    = rd_q;
			step_dn = (state_q == alen_pkg::S_SHIFT_UP);
		end
		nxt = step_dn ? (base - CW'(1)) : (base + CW'(1));
		hit = (ram_rdata == data_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			alen_pkg::S_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) state_d = alen_pkg::S_IDLE;
			end
			alen_pkg::S_IDLE: begin
				if (accept) begin
					case (in_item.kind)
						alen_pkg::K_INSERT: begin
							if (in_pos > fill_q || fill_q >= cap || in_pos == fill_q)
								state_d = alen_pkg::S_FINISH;
							else
								state_d = alen_pkg::S_SHIFT_UP;
						end
						alen_pkg::K_DELETE: begin
							if (in_pos >= fill_q || nxt == fill_q)
								state_d = alen_pkg::S_FINISH;
							else
								state_d = alen_pkg::S_SHIFT_DN;
						end
						alen_pkg::K_SEARCH: begin
							state_d = (fill_q == '0) ? alen_pkg::S_FINISH : alen_pkg::S_SEARCH;
						end
						default: state_d = alen_pkg::S_FINISH;
					endcase
				end
			end
			alen_pkg::S_SHIFT_UP: begin
				if (rd_q == pos_w) state_d = alen_pkg::S_INS_PUT;
			end
			alen_pkg::S_INS_PUT: state_d = alen_pkg::S_FINISH;
			alen_pkg::S_SHIFT_DN: begin
				if (nxt == fill_q) state_d = alen_pkg::S_FINISH;
			end
			alen_pkg::S_SEARCH: begin
				if (hit || nxt == fill_q) state_d = alen_pkg::S_FINISH;
			end
			alen_pkg::S_FINISH: begin
				if (!out_valid_q || out_ready) state_d = alen_pkg::S_IDLE;
			end
			default: state_d = alen_pkg::S_CLEAR;
		endcase
	end

	// outputs and datapath controls
	always_comb begin
		in_ready  = (state_q == alen_pkg::S_IDLE);
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		waddr_c   = wr_q;
		raddr_c   = nxt;
		ram_wdata = ram_rdata;
		fill_d    = fill_q;
		rd_d      = rd_q;
		wr_d      = wr_q;
		status_d  = status_q;
		found_d   = found_q;
		rsel_d    = rsel_q;
		load_out  = 1'b0;
		unique case (state_q)
			alen_pkg::S_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
			end
			alen_pkg::S_IDLE: begin
				if (accept) begin
					status_d = alen_pkg::ST_OK;
					found_d  = 1'b0;
					rsel_d   = 1'b0;
					case (in_item.kind)
						alen_pkg::K_APPEND: begin
							if (fill_q >= cap) begin
								status_d = alen_pkg::ST_OVERFLOW;
							end else begin
								ram_we    = 1'b1;
								waddr_c   = fill_q;
								ram_wdata = in_item.data_value;
								fill_d    = fill_q + CW'(1);
							end
						end
						alen_pkg::K_INSERT: begin
							if (in_pos > fill_q) begin
								status_d = alen_pkg::ST_BADPOS;
							end else if (fill_q >= cap) begin
								status_d = alen_pkg::ST_OVERFLOW;
							end else if (in_pos == fill_q) begin
								ram_we    = 1'b1;
								waddr_c   = in_pos;
								ram_wdata = in_item.data_value;
								fill_d    = fill_q + CW'(1);
							end else begin
								ram_re = 1'b1;
								rd_d   = nxt;
								wr_d   = fill_q;
							end
						end
						alen_pkg::K_DELETE: begin
							if (in_pos >= fill_q) begin
								status_d = alen_pkg::ST_BADPOS;
							end else if (nxt == fill_q) begin
								fill_d = fill_q - CW'(1);
							end else begin
								ram_re = 1'b1;
								rd_d   = nxt;
								wr_d   = in_pos;
							end
						end
						alen_pkg::K_READ: begin
							if (in_pos >= cap) begin
								status_d = alen_pkg::ST_BADPOS;
							end else begin
								ram_re  = 1'b1;
								raddr_c = in_pos;
								rsel_d  = 1'b1;
							end
						end
						alen_pkg::K_EDIT: begin
							if (in_pos >= cap) begin
								status_d = alen_pkg::ST_BADPOS;
							end else begin
								ram_we    = 1'b1;
								waddr_c   = in_pos;
								ram_wdata = in_item.data_value;
							end
						end
						alen_pkg::K_SEARCH: begin
							if (fill_q != '0) begin
								ram_re  = 1'b1;
								raddr_c = '0;
								rd_d    = '0;
							end
						end
						default: ;
					endcase
				end
			end
			alen_pkg::S_SHIFT_UP: begin
				ram_we = 1'b1;
				if (rd_q != pos_w) begin
					ram_re = 1'b1;
					rd_d   = nxt;
					wr_d   = rd_q;
				end
			end
			alen_pkg::S_INS_PUT: begin
				ram_we    = 1'b1;
				waddr_c   = pos_w;
				ram_wdata = data_q;
				fill_d    = fill_q + CW'(1);
			end
			alen_pkg::S_SHIFT_DN: begin
				ram_we = 1'b1;
				if (nxt == fill_q) begin
					fill_d = fill_q - CW'(1);
				end else begin
					ram_re = 1'b1;
					rd_d   = nxt;
					wr_d   = rd_q;
				end
			end
			alen_pkg::S_SEARCH: begin
				if (hit) begin
					found_d = 1'b1;
				end else if (nxt != fill_q) begin
					ram_re = 1'b1;
					rd_d   = nxt;
				end
			end
			alen_pkg::S_FINISH: begin
				load_out = !out_valid_q || out_ready;
			end
			default: ;
		endcase
		ram_waddr = (state_q == alen_pkg::S_CLEAR) ? clr_q : to_addr(waddr_c);
		ram_raddr = to_addr(raddr_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= alen_pkg::S_CLEAR;
			clr_q       <= '0;
			fill_q      <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			status_q    <= alen_pkg::ST_OK;
			found_q     <= 1'b0;
			rsel_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			rd_q     <= rd_d;
			wr_q     <= wr_d;
			status_q <= status_d;
			found_q  <= found_d;
			rsel_q   <= rsel_d;
			if (state_q == alen_pkg::S_CLEAR) clr_q <= clr_q + AW'(1);
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q  <= in_item.position;
			data_q <= in_item.data_value;
		end
		if (load_out) begin
			out_res_q.status        <= status_q;
			out_res_q.read_value    <= rsel_q ? ram_rdata : '0;
			out_res_q.element_count <= fill_q;
			out_res_q.found         <= found_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	`ALEN_ASSERT_ALWAYS(a_fill_bound, fill_q <= CW'(CAP_MAX), "fill level above capacity limit")
	`ALEN_ASSERT_IMP(a_shift_up_floor, state_q == alen_pkg::S_SHIFT_UP, rd_q >= pos_w, "insert walk passed its position")
	`ALEN_ASSERT_NXT(a_append_grows, accept && in_item.kind == alen_pkg::K_APPEND && fill_q < cap, fill_q == $past(fill_q) + 7'd1, "append did not grow fill level")
	`ALEN_ASSERT_NXT(a_finish_loads, state_q == alen_pkg::S_FINISH && (!out_valid_q || out_ready), out_valid_q && state_q == alen_pkg::S_IDLE, "finished result not presented")

endmodule

### rtl/array_list_engine.sv
// packed list engine: holds up to min(capacity, DEPTH) signed 32-bit entries and a fill level.
// one operation per s_ transfer (kind in s_tuser), one result per m_ transfer. after reset the
// store is cleared one entry a cycle with s_tready low; cfg writes are taken throughout. append,
// edit, read, unused kinds, insert at the end and every rejected operation go from idle straight
// to the result. insert below the end moves the entries from the position on up by one and writes
// the new one; delete moves those above the position down; search compares from the front until
// a hit or the end. the single store port moves or compares one entry per cycle. a finished
// result sits in the output register, so the next operation may be taken while it waits.
module array_list_engine #(
	parameter int DEPTH = alen_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// operation in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // data_value[31:0], position[37:32], zero pad
	input  logic [2:0]  s_tuser,   // kind[2:0]
	// result out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // status[1:0], read_value[33:2], element_count[40:34],
	                               // found[41], zero pad
	// capacity register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data   // capacity_in_use
);

	localparam int AW = $clog2(DEPTH);

	logic [alen_pkg::CNT_W-1:0]         cap_q;
	alen_pkg::item_t                    item;
	alen_pkg::result_t                  res;
	logic                               ram_we;
	logic [AW-1:0]                      ram_waddr;
	logic signed [alen_pkg::DATA_W-1:0] ram_wdata;
	logic                               ram_re;
	logic [AW-1:0]                      ram_raddr;
	logic signed [alen_pkg::DATA_W-1:0] ram_rdata;

	// capacity register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= alen_pkg::CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	// unpack the operation transfer
	always_comb begin
		item.kind       = alen_pkg::kind_t'(s_tuser);
		item.data_value = s_tdata[31:0];
		item.position   = s_tdata[37:32];
	end

	// pack the result, first field lowest
	assign m_tdata = {6'b0, res.found, res.element_count, res.read_value, res.status};

	alen_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (item),
		.cap_cfg   (cap_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// entry store
	alen_ram #(
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

### sim/array_list_engine_test.sv
module array_list_engine_test;

	// stimulus and reply views at the block's widths
	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] data;
		logic [5:0]  pos;
	} list_op_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] read_value;
		logic [6:0]  count;
		logic        found;
	} list_reply_t;

	// the two selector codes the block leaves unused
	localparam logic [2:0] KIND_SPARE_6 = 3'd6;
	localparam logic [2:0] KIND_SPARE_7 = 3'd7;

	localparam int LIST_DEPTH     = 64;
	localparam int MAX_GAP        = 8;
	localparam int SETTLE_CYCLES  = 80;    // longer than an insert over a full list
	localparam int LONG_HOLD      = 300;   // receiver hold-off for the back-pressure phase
	localparam int MAX_PRINTED    = 50;
	localparam int TIMEOUT_UNITS  = 2000000;

	localparam logic [31:0] VAL_MAX  = 32'h7fff_ffff;
	localparam logic [31:0] VAL_MIN  = 32'h8000_0000;
	localparam logic [31:0] VAL_ONES = 32'hffff_ffff;
	localparam logic [31:0] VAL_ZERO = 32'h0000_0000;

	// clock, reset and block inputs, all known from time zero
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic [39:0] s_tdata   = '0;   // data_value[31:0], position[37:32], zero pad
	logic [2:0]  s_tuser   = '0;   // kind[2:0]
	logic        m_tready  = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [6:0]  cfg_data  = '0;   // capacity_in_use
	logic        s_tready;
	logic        m_tvalid;
	logic [47:0] m_tdata;          // status[1:0], read_value[33:2], element_count[40:34],
	                               // found[41], zero pad
	logic        cfg_ready;

	// shadow of the list as the block should hold it
	logic [31:0] shadow_entries [0:LIST_DEPTH-1];
	int          shadow_fill     = 0;
	int          shadow_capacity = alen_pkg::CAP_RESET;

	list_op_t    ops_waiting [$];   // operations not yet offered
	list_reply_t replies_due [$];   // predicted replies, oldest first

	int  sent_count     = 0;
	int  taken_count    = 0;
	int  result_count   = 0;
	int  mismatch_count = 0;
	int  send_wait      = 0;
	int  recv_wait      = 0;
	int  recv_mark      = 0;
	int  hold_left      = 0;
	int  hold_requests  = 0;
	int  hold_served    = 0;
	bit  send_gaps_on   = 1'b1;
	bit  recv_gaps_on   = 1'b1;

	array_list_engine u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// one operation applied to the shadow list, giving the reply the block owes
	task automatic apply_list_op(input list_op_t op, output list_reply_t r);
		int i;
		int p;
		int cap;
		p   = op.pos;
		cap = (shadow_capacity > LIST_DEPTH) ? LIST_DEPTH : shadow_capacity;
		r   = '0;
		r.status = alen_pkg::ST_OK;
		case (op.kind)
			alen_pkg::K_APPEND: begin
				if (shadow_fill >= cap) begin
					r.status = alen_pkg::ST_OVERFLOW;
				end else begin
					shadow_entries[shadow_fill] = op.data;
					shadow_fill++;
				end
			end
			alen_pkg::K_INSERT: begin
				// a position past the end is checked before a full list
				if (p > shadow_fill) begin
					r.status = alen_pkg::ST_BADPOS;
				end else if (shadow_fill >= cap) begin
					r.status = alen_pkg::ST_OVERFLOW;
				end else begin
					for (i = shadow_fill; i > p; i--)
						shadow_entries[i] = shadow_entries[i-1];
					shadow_entries[p] = op.data;
					shadow_fill++;
				end
			end
			alen_pkg::K_DELETE: begin
				// the freed top slot keeps its old value
				if (p >= shadow_fill) begin
					r.status = alen_pkg::ST_BADPOS;
				end else begin
					for (i = p; i + 1 < shadow_fill; i++)
						shadow_entries[i] = shadow_entries[i+1];
					shadow_fill--;
				end
			end
			alen_pkg::K_READ: begin
				if (p >= cap)
					r.status = alen_pkg::ST_BADPOS;
				else
					r.read_value = shadow_entries[p];
			end
			alen_pkg::K_EDIT: begin
				if (p >= cap)
					r.status = alen_pkg::ST_BADPOS;
				else
					shadow_entries[p] = op.data;
			end
			alen_pkg::K_SEARCH: begin
				for (i = 0; i < shadow_fill; i++)
					if (shadow_entries[i] == op.data)
						r.found = 1'b1;
			end
			default: begin
				// unused kinds leave everything alone
			end
		endcase
		r.count = shadow_fill[6:0];
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("mismatch at result %0d: %s got %h expected %h",
				result_count, what, got, want);
	endtask

	// sampling at the rising edge: cfg writes, accepted operations, replies
	always @(posedge clk) begin : sample_edge
		list_reply_t got;
		list_reply_t want;
		list_op_t    op;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				shadow_capacity = cfg_data;
			// check the reply before queuing a new prediction on the same edge
			if (m_tvalid && m_tready) begin
				got.status     = m_tdata[1:0];
				got.read_value = m_tdata[33:2];
				got.count      = m_tdata[40:34];
				got.found      = m_tdata[41];
				if (replies_due.size() == 0) begin
					report_mismatch("reply with nothing outstanding", m_tdata[31:0], '0);
				end else begin
					want = replies_due.pop_front();
					if (got.status !== want.status)
						report_mismatch("status", 32'(got.status), 32'(want.status));
					if (got.read_value !== want.read_value)
						report_mismatch("read_value", got.read_value, want.read_value);
					if (got.count !== want.count)
						report_mismatch("element_count", 32'(got.count), 32'(want.count));
					if (got.found !== want.found)
						report_mismatch("found", 32'(got.found), 32'(want.found));
				end
				result_count++;
			end
			if (s_tvalid && s_tready) begin
				op.kind = s_tuser;
				op.data = s_tdata[31:0];
				op.pos  = s_tdata[37:32];
				apply_list_op(op, want);
				replies_due.push_back(want);
				taken_count++;
			end
		end
	end

	// sender: holds an offered operation until its transfer, then waits its drawn gap
	always @(negedge clk) begin : send_side
		list_op_t op;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && taken_count != sent_count) begin
			// still waiting for the transfer
		end else if (send_wait != 0) begin
			send_wait--;
			s_tvalid <= 1'b0;
		end else if (ops_waiting.size() != 0) begin
			op = ops_waiting.pop_front();
			s_tdata  <= {2'b00, op.pos, op.data};
			s_tuser  <= op.kind;
			s_tvalid <= 1'b1;
			sent_count++;
			send_wait = send_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// long hold-off, counted apart from the per-reply stalls
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_left   <= LONG_HOLD;
			hold_served <= hold_requests;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver: a fresh stall is drawn after each reply transfer
	always @(negedge clk) begin
		if (result_count != recv_mark) begin
			recv_mark = result_count;
			recv_wait = recv_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
		end
		if (hold_left != 0) begin
			m_tready <= 1'b0;
		end else if (recv_wait != 0) begin
			recv_wait--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic queue_op(input logic [2:0] kind, input logic [31:0] data,
			input logic [5:0] pos);
		list_op_t op;
		op.kind = kind;
		op.data = data;
		op.pos  = pos;
		ops_waiting.push_back(op);
	endtask

	// block is idle once nothing is pending or outstanding and it has had time to settle
	task automatic wait_until_quiet();
		while (ops_waiting.size() != 0 || taken_count != sent_count || replies_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [6:0] value);
		@(negedge clk);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// data values, half of them from a small pool, so that searches hit now and then
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 11))
			0: pick_value = VAL_MAX;
			1: pick_value = VAL_MIN;
			2: pick_value = VAL_ZERO;
			3: pick_value = VAL_ONES;
			4: pick_value = 32'd7;
			5: pick_value = 32'h1234_5678;
			default: pick_value = $urandom;
		endcase
	endfunction

	// random operations biased towards positions that land inside the list
	task automatic queue_random_ops(input int n, input int cap);
		int k;
		int roll;
		int top;
		logic [2:0] kind;
		logic [5:0] pos;
		top = (cap > LIST_DEPTH - 1) ? LIST_DEPTH - 1 : cap;
		for (k = 0; k < n; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < 28)      kind = alen_pkg::K_APPEND;
			else if (roll < 48) kind = alen_pkg::K_INSERT;
			else if (roll < 68) kind = alen_pkg::K_DELETE;
			else if (roll < 80) kind = alen_pkg::K_READ;
			else if (roll < 88) kind = alen_pkg::K_EDIT;
			else if (roll < 97) kind = alen_pkg::K_SEARCH;
			else if (roll < 99) kind = KIND_SPARE_6;
			else                kind = KIND_SPARE_7;
			if ($urandom_range(0, 4) == 0)
				pos = 6'($urandom_range(0, LIST_DEPTH - 1));
			else
				pos = 6'($urandom_range(0, top));
			queue_op(kind, pick_value(), pos);
		end
	endtask

	task automatic random_phase(input int cap, input int n, input bit sgaps, input bit rgaps);
		write_capacity(cap[6:0]);
		@(posedge clk);
		send_gaps_on = sgaps;
		recv_gaps_on = rgaps;
		queue_random_ops(n, cap);
		wait_until_quiet();
	endtask

	initial begin
		// the store is cleared at reset
		foreach (shadow_entries[i]) shadow_entries[i] = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// reset capacity of six, empty list cleared at reset
		queue_op(alen_pkg::K_READ,   VAL_ONES, 6'd0);
		queue_op(alen_pkg::K_SEARCH, VAL_ZERO, 6'd0);        // nothing occupied yet
		queue_op(alen_pkg::K_DELETE, VAL_ZERO, 6'd0);        // delete on an empty slot
		queue_op(alen_pkg::K_INSERT, VAL_ONES, 6'd1);        // insert past the end
		queue_op(alen_pkg::K_APPEND, VAL_MAX,  6'd63);
		queue_op(alen_pkg::K_APPEND, VAL_MIN,  6'd0);
		queue_op(alen_pkg::K_INSERT, VAL_ONES, 6'd0);
		queue_op(alen_pkg::K_INSERT, VAL_ZERO, 6'd3);        // insert right at the end
		queue_op(alen_pkg::K_SEARCH, VAL_MIN,  6'd63);
		queue_op(alen_pkg::K_EDIT,   32'h5555_5555, 6'd5);   // edit above the fill level
		queue_op(alen_pkg::K_READ,   VAL_ZERO, 6'd5);
		queue_op(alen_pkg::K_READ,   VAL_ZERO, 6'd6);        // read at capacity
		queue_op(alen_pkg::K_EDIT,   VAL_ONES, 6'd63);       // edit far out of range
		queue_op(alen_pkg::K_APPEND, 32'h0f0f_0f0f, 6'd0);
		queue_op(alen_pkg::K_APPEND, 32'haaaa_aaaa, 6'd0);
		queue_op(alen_pkg::K_APPEND, VAL_ONES, 6'd0);        // append when full
		queue_op(alen_pkg::K_INSERT, VAL_ONES, 6'd7);        // past the end wins over full
		queue_op(alen_pkg::K_INSERT, VAL_ONES, 6'd2);        // insert when full
		queue_op(alen_pkg::K_DELETE, VAL_ZERO, 6'd5);
		queue_op(alen_pkg::K_READ,   VAL_ZERO, 6'd5);        // freed slot keeps its value
		queue_op(alen_pkg::K_DELETE, VAL_ZERO, 6'd0);
		queue_op(alen_pkg::K_SEARCH, 32'haaaa_aaaa, 6'd0);   // stale slot must not match
		queue_op(KIND_SPARE_6, VAL_ONES, 6'd63);
		queue_op(KIND_SPARE_7, VAL_MAX,  6'd21);
		wait_until_quiet();

		// zero capacity: appends and inserts overflow, reads and edits are out of range
		write_capacity(7'd0);
		queue_op(alen_pkg::K_APPEND, VAL_ONES, 6'd0);
		queue_op(alen_pkg::K_INSERT, VAL_ONES, 6'd0);
		queue_op(alen_pkg::K_READ,   VAL_ZERO, 6'd0);
		queue_op(alen_pkg::K_EDIT,   VAL_ONES, 6'd0);
		queue_op(alen_pkg::K_SEARCH, VAL_MAX,  6'd0);
		wait_until_quiet();

		// capacity lowered below the fill level keeps the entries
		write_capacity(7'd2);
		queue_op(alen_pkg::K_APPEND, VAL_ONES, 6'd0);
		queue_op(alen_pkg::K_INSERT, VAL_ONES, 6'd0);
		queue_op(alen_pkg::K_READ,   VAL_ZERO, 6'd1);
		wait_until_quiet();

		random_phase(64,  200, 1'b1, 1'b1);
		random_phase(1,    60, 1'b0, 1'b1);
		random_phase(127, 150, 1'b1, 1'b0);
		random_phase(5,   100, 1'b0, 1'b0);

		// back-pressure: receiver holds off while the sender keeps offering
		write_capacity(7'd64);
		@(posedge clk);
		send_gaps_on = 1'b0;
		recv_gaps_on = 1'b1;
		hold_requests++;
		queue_random_ops(150, 64);
		wait_until_quiet();

		random_phase(33,  150, 1'b1, 1'b1);
		random_phase(0,    30, 1'b1, 1'b0);
		random_phase(64,  160, 1'b0, 1'b1);
		random_phase($urandom_range(1, 127), 100, 1'b1, 1'b1);

		if (mismatch_count == 0) begin
			$display("array_list_engine verification clean");
		end else begin
			$display("array_list_engine verification failed");
		end
		$finish;
	end

	initial begin
		#TIMEOUT_UNITS;
		$display("array_list_engine verification failed");
		$finish;
	end

endmodule
